>>> src/sse_diagonal_update_defines.svh
// Assertion macros for the diagonal-update RTL.
`ifndef SSE_DIAGONAL_UPDATE_DEFINES_SVH
`define SSE_DIAGONAL_UPDATE_DEFINES_SVH

// Same-cycle implication on the module clock and reset.
`define SDU_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication on the module clock and reset.
`define SDU_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> src/sdu_pkg.sv
// Types, constants and helper functions for the diagonal-update block.
package sdu_pkg;

    localparam int MAX_SPINS   = 64;
    localparam int RAND_BITS   = 16;
    localparam int SITE_W      = 6;
    localparam int NSP_W       = 7;
    localparam int COUNT_W     = 16;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic signed [6:0] SITE_NONE = -7'sd1;

    typedef enum logic [2:0] {
        CFG_LIST_LENGTH  = 3'd0,
        CFG_CHAIN_LENGTH = 3'd1,
        CFG_BETA         = 3'd2,
        CFG_START_SPINS  = 3'd3
    } t_cfg_idx;

    typedef enum logic [1:0] {
        KIND_UNIT    = 2'd0,
        KIND_DIAG    = 2'd1,
        KIND_OFFDIAG = 2'd2
    } t_kind;

    typedef enum logic [1:0] {
        OP_INSERT,
        OP_REMOVE,
        OP_FLIP,
        OP_PASS
    } t_op;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL1,
        S_MUL2,
        S_MUL3,
        S_DONE
    } t_state;

    typedef struct packed {
        t_op                      op;
        logic [1:0]               kind;
        logic [SITE_W-1:0]        site;
        logic [RAND_BITS-1:0]     rs;
        logic [RAND_BITS-1:0]     ra;
        logic                     first;
        logic [COUNT_W-1:0]       start_count;
    } t_slot;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

    function automatic logic [NSP_W-1:0] sat_chain(input logic [NSP_W-1:0] cl);
        logic [NSP_W-1:0] r;
        r = cl;
        if (cl < NSP_W'(2)) begin
            r = NSP_W'(2);
        end else if (cl > NSP_W'(MAX_SPINS)) begin
            r = NSP_W'(MAX_SPINS);
        end
        return r;
    endfunction

    function automatic logic [SITE_W-1:0] next_site(input logic [SITE_W-1:0] s,
                                                    input logic [NSP_W-1:0] n);
        logic [NSP_W-1:0] nx;
        nx = {1'b0, s} + NSP_W'(1);
        return (nx >= n) ? '0 : nx[SITE_W-1:0];
    endfunction

endpackage

>>> src/sdu_queue.sv
// Two-entry queue that carries classified slots from the front to the back.
module sdu_queue
    import sdu_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_push,
    input  t_slot     i_data,
    input  logic      i_pop,
    output t_slot     o_head,
    output t_q_status o_status
);

    t_slot             r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + QPTR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + QPTR_W'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + QCNT_W'(1);
            end else if (!i_push && i_pop) begin
                r_count <= r_count - QCNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    assign o_head         = r_mem[r_rd_ptr];
    assign o_status.full  = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign o_status.empty = (r_count == '0);

endmodule

>>> src/sdu_front.sv
// Front end: accepts slots and classifies them into back-end operations.
module sdu_front
    import sdu_pkg::*;
(
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic [1:0]           i_slot_kind,
    input  logic [SITE_W-1:0]    i_slot_site,
    input  logic [RAND_BITS-1:0] i_rand_site,
    input  logic [RAND_BITS-1:0] i_rand_accept,
    input  logic                 i_sweep_first,
    input  logic [COUNT_W-1:0]   i_start_count,
    input  logic [NSP_W-1:0]     i_n_sp,
    input  t_q_status            i_q,
    output logic                 o_push,
    output t_slot                o_entry
);

    logic in_range;
    t_op  op;

    assign in_range = ({1'b0, i_slot_site} < i_n_sp);

    always_comb begin
        unique case (t_kind'(i_slot_kind))
            KIND_UNIT:    op = OP_INSERT;
            KIND_DIAG:    op = in_range ? OP_REMOVE : OP_PASS;
            KIND_OFFDIAG: op = in_range ? OP_FLIP : OP_PASS;
            default:      op = OP_PASS;
        endcase
    end

    assign o_in_ready          = !i_q.full;
    assign o_push              = i_in_valid && !i_q.full;
    assign o_entry.op          = op;
    assign o_entry.kind        = i_slot_kind;
    assign o_entry.site        = i_slot_site;
    assign o_entry.rs          = i_rand_site;
    assign o_entry.ra          = i_rand_accept;
    assign o_entry.first       = i_sweep_first;
    assign o_entry.start_count = i_start_count;

endmodule

>>> src/sdu_back.sv
// Back end: shared multiplier sequencer, spin and count state, result register.
`include "sse_diagonal_update_defines.svh"

module sdu_back
    import sdu_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_slot                    i_head,
    input  t_q_status                i_q,
    output logic                     o_pop,
    input  logic [15:0]              i_list_length,
    input  logic [NSP_W-1:0]         i_n_sp,
    input  logic [15:0]              i_beta,
    input  logic [MAX_SPINS-1:0]     i_start_spins,
    output logic                     o_out_valid,
    input  logic                     i_out_ready,
    output logic [1:0]               o_new_kind,
    output logic signed [6:0]        o_new_site
);

    t_state                r_state;
    t_state                n_state;
    t_slot                 r_item;
    logic [MAX_SPINS-1:0]  r_spins;
    logic [COUNT_W-1:0]    r_count;
    logic [COUNT_W-1:0]    n_count;
    logic [39:0]           r_prod;
    logic [22:0]           r_rhs;
    logic [SITE_W-1:0]     r_s1;
    logic                  r_out_valid;
    logic [1:0]            r_new_kind;
    logic [1:0]            n_new_kind;
    logic signed [6:0]     r_new_site;
    logic signed [6:0]     n_new_site;

    logic                  out_free;
    logic                  done_fire;
    logic                  load;
    logic signed [17:0]    gap;
    logic signed [17:0]    gap_p1;
    logic [22:0]           mul_a;
    logic [16:0]           mul_b;
    logic [39:0]           mul_p;
    logic [SITE_W-1:0]     s2_unit;
    logic [SITE_W-1:0]     s2_flip;
    logic                  ins_ok;
    logic                  rem_ok;
    logic                  prod_en;

    assign out_free  = !r_out_valid || i_out_ready;
    assign done_fire = (r_state == S_DONE) && out_free;
    assign o_pop     = ((r_state == S_IDLE) || done_fire) && !i_q.empty;
    assign load      = o_pop && i_head.first;

    assign gap    = $signed({2'b00, i_list_length}) - $signed({2'b00, r_count});
    assign gap_p1 = gap + 18'sd1;

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (r_state)
            S_MUL1: begin
                mul_a = (r_item.op == OP_INSERT) ? 23'(r_item.rs) : 23'(r_item.ra);
                mul_b = 17'(i_n_sp);
            end
            S_MUL2: begin
                mul_a = (r_item.op == OP_INSERT) ? 23'(i_n_sp) : r_prod[22:0];
                mul_b = 17'(i_beta);
            end
            S_MUL3: begin
                mul_a = 23'(r_item.ra);
                mul_b = 17'(gap[15:0]);
            end
            default: begin
            end
        endcase
    end

    assign mul_p   = {17'b0, mul_a} * {23'b0, mul_b};
    assign prod_en = (r_state == S_MUL1) || (r_state == S_MUL2)
                     || ((r_state == S_MUL3) && (r_item.op == OP_INSERT));

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (o_pop) n_state = S_MUL1;
            end
            S_MUL1: begin
                if (r_item.op == OP_INSERT || r_item.op == OP_REMOVE) begin
                    n_state = S_MUL2;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_MUL2: n_state = S_MUL3;
            S_MUL3: n_state = S_DONE;
            S_DONE: begin
                if (o_pop) begin
                    n_state = S_MUL1;
                end else if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign s2_unit = next_site(r_s1, i_n_sp);
    assign s2_flip = next_site(r_item.site, i_n_sp);
    assign ins_ok  = (r_spins[r_s1] != r_spins[s2_unit]) && !gap[17]
                     && ({r_prod[31:0], 1'b0} < {2'b00, r_rhs, 8'b0});
    assign rem_ok  = !gap_p1[17] && (gap_p1 != 18'sd0)
                     && ({2'b00, r_prod} < {gap_p1[16:0], 25'b0});

    always_comb begin
        n_new_kind = r_item.kind;
        n_new_site = $signed({1'b0, r_item.site});
        n_count    = r_count;
        unique case (r_item.op)
            OP_INSERT: begin
                n_new_kind = KIND_UNIT;
                n_new_site = SITE_NONE;
                if (ins_ok) begin
                    n_new_kind = KIND_DIAG;
                    n_new_site = $signed({1'b0, r_s1});
                    if (r_count != '1) n_count = r_count + COUNT_W'(1);
                end
            end
            OP_REMOVE: begin
                if (rem_ok) begin
                    n_new_kind = KIND_UNIT;
                    n_new_site = SITE_NONE;
                    if (r_count != '0) n_count = r_count - COUNT_W'(1);
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_spins     <= '0;
            r_count     <= '0;
        end else begin
            r_state <= n_state;
            if (done_fire) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (load) begin
                r_spins <= i_start_spins;
                r_count <= i_head.start_count;
            end else begin
                if (done_fire) begin
                    r_count <= n_count;
                end
                if (r_state == S_MUL1 && r_item.op == OP_FLIP) begin
                    r_spins <= r_spins ^ (MAX_SPINS'(1) << r_item.site)
                                       ^ (MAX_SPINS'(1) << s2_flip);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_item <= i_head;
        end
        if (prod_en) begin
            r_prod <= mul_p;
        end
        if (r_state == S_MUL2 && r_item.op == OP_INSERT) begin
            r_s1 <= r_prod[RAND_BITS+SITE_W-1:RAND_BITS];
        end
        if (r_state == S_MUL3 && r_item.op == OP_INSERT) begin
            r_rhs <= r_prod[22:0];
        end
        if (done_fire) begin
            r_new_kind <= n_new_kind;
            r_new_site <= n_new_site;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_new_kind  = r_new_kind;
    assign o_new_site  = r_new_site;

    `SDU_ASSERT_SAME(ast_pop_state, o_pop, r_state == S_IDLE || r_state == S_DONE, "slot taken while busy")
    `SDU_ASSERT_NEXT(ast_spins_hold, !load && !(r_state == S_MUL1 && r_item.op == OP_FLIP), $stable(r_spins), "spin vector changed without flip or reload")
    `SDU_ASSERT_NEXT(ast_count_hold, !load && !done_fire, $stable(r_count), "count changed without result or reload")

endmodule

>>> src/sse_diagonal_update.sv
// Top level of the diagonal-update block: configuration registers and wiring.
//
// Channel   Direction  Handshake                   Word
// in        input      i_in_valid / o_in_ready     slot kind, site, randoms, sweep start
// out       output     o_out_valid / i_out_ready   new kind and signed site
// cfg       input      i_cfg_valid / o_cfg_ready   register index and data
//
// A unit or in-range diagonal slot runs through the back-end states MUL1, MUL2, MUL3
// and DONE, using the one shared multiplier, and DONE can overlap the next pop.
// Off-diagonal and pass-through slots go from MUL1 straight to DONE.
// Reset is synchronous and returns the configuration, spins and count to their defaults.
// A two-entry queue and an output register let input and output stall independently.
module sse_diagonal_update
    import sdu_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic [1:0]           i_slot_kind,
    input  logic [5:0]           i_slot_site,
    input  logic [15:0]          i_rand_site,
    input  logic [15:0]          i_rand_accept,
    input  logic                 i_sweep_first,
    input  logic [15:0]          i_start_count,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic [1:0]           o_new_kind,
    output logic signed [6:0]    o_new_site,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [2:0]           i_cfg_index,
    input  logic [63:0]          i_cfg_data
);

    logic [15:0]          r_list_length;
    logic [NSP_W-1:0]     r_chain_length;
    logic [15:0]          r_beta;
    logic [MAX_SPINS-1:0] r_start_spins;
    logic [NSP_W-1:0]     n_sp;
    logic                 push;
    logic                 pop;
    t_slot                entry;
    t_slot                head;
    t_q_status            q_status;

    assign o_cfg_ready = 1'b1;
    assign n_sp        = sat_chain(r_chain_length);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_list_length  <= 16'd1024;
            r_chain_length <= NSP_W'(16);
            r_beta         <= 16'd256;
            r_start_spins  <= '0;
        end else if (i_cfg_valid) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_LIST_LENGTH:  r_list_length  <= i_cfg_data[15:0];
                CFG_CHAIN_LENGTH: r_chain_length <= i_cfg_data[NSP_W-1:0];
                CFG_BETA:         r_beta         <= i_cfg_data[15:0];
                CFG_START_SPINS:  r_start_spins  <= i_cfg_data[MAX_SPINS-1:0];
                default: begin
                end
            endcase
        end
    end

    sdu_front u_front (
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_slot_kind   (i_slot_kind),
        .i_slot_site   (i_slot_site),
        .i_rand_site   (i_rand_site),
        .i_rand_accept (i_rand_accept),
        .i_sweep_first (i_sweep_first),
        .i_start_count (i_start_count),
        .i_n_sp        (n_sp),
        .i_q           (q_status),
        .o_push        (push),
        .o_entry       (entry)
    );

    sdu_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_data   (entry),
        .i_pop    (pop),
        .o_head   (head),
        .o_status (q_status)
    );

    sdu_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_head        (head),
        .i_q           (q_status),
        .o_pop         (pop),
        .i_list_length (r_list_length),
        .i_n_sp        (n_sp),
        .i_beta        (r_beta),
        .i_start_spins (r_start_spins),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_new_kind    (o_new_kind),
        .o_new_site    (o_new_site)
    );

endmodule
